[rtl/bbtti_pkg.sv]
package bbtti_pkg;

   // result width and the time cap in whole seconds
   localparam int RES_WIDTH   = 24;
   localparam int CAP_SECONDS = 1000;
   localparam int NUM_AXES    = 3;

   // register map of the configuration port
   localparam int CSR_IDX_WIDTH = 3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_NORTH_LOW  = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_NORTH_HIGH = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_EAST_LOW   = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_EAST_HIGH  = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UP_LOW     = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] REG_UP_HIGH    = 3'd5;

   // how one axis contributes to the minimum
   typedef enum logic [1:0] {
      CAND_NONE,
      CAND_DIRECT,
      CAND_QUOT
   } cand_type;

   typedef struct packed {
      cand_type kind;
      logic     neg;
   } lane_ctl_type;

   typedef struct packed {
      logic                        valid;
      lane_ctl_type [NUM_AXES-1:0] lane;
   } pipe_ctl_type;

endpackage

[rtl/bbtti_prep.sv]
module bbtti_prep
   import bbtti_pkg::*;
#(
   parameter int FRAC_BITS = 8,
   parameter int POS_WIDTH = 24,
   parameter int VEL_WIDTH = 16,
   parameter int QW        = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  take,
   input  logic [NUM_AXES-1:0][POS_WIDTH-1:0]    pos,
   input  logic [NUM_AXES-1:0][VEL_WIDTH-1:0]    vel,
   input  logic [NUM_AXES-1:0][POS_WIDTH-1:0]    lo,
   input  logic [NUM_AXES-1:0][POS_WIDTH-1:0]    hi,
   output pipe_ctl_type                          ctl_out,
   output logic [NUM_AXES-1:0][VEL_WIDTH-1:0]    rem_out,
   output logic [NUM_AXES-1:0][VEL_WIDTH-1:0]    den_out,
   output logic [NUM_AXES-1:0][QW-1:0]           dq_out
);

   localparam int P   = POS_WIDTH;
   localparam int V   = VEL_WIDTH;
   localparam int DRW = (P > V ? P : V) + 2;

   pipe_ctl_type                     ctl_ff, ctl_in;
   logic [NUM_AXES-1:0][V-1:0]       den_ff, den_in;
   logic [NUM_AXES-1:0][QW-1:0]      dq_ff, dq_in;

   // per axis: choose the case, set up dividend and divisor magnitudes
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      logic signed [P:0]     dl, dh, num;
      logic signed [V:0]     vx, dn;
      logic signed [DRW-1:0] direct;
      logic [P:0]            num_abs;
      logic [V:0]            den_abs;
      logic                  le, ge, vneg, vzero;

      always_comb begin
         dl     = $signed({pos[a][P-1], pos[a]}) - $signed({lo[a][P-1], lo[a]});
         dh     = $signed({hi[a][P-1], hi[a]}) - $signed({pos[a][P-1], pos[a]});
         vx     = $signed({vel[a][V-1], vel[a]});
         le     = $signed(pos[a]) <= $signed(lo[a]);
         ge     = $signed(pos[a]) >= $signed(hi[a]);
         vneg   = vel[a][V-1];
         vzero  = (vel[a] == '0);
         num    = dl;
         dn     = vx;
         direct = DRW'(dl) + DRW'(vx);
         ctl_in.lane[a].kind = CAND_QUOT;
         if (le) begin
            if (vneg || vzero) begin
               ctl_in.lane[a].kind = CAND_DIRECT;
            end
         end else if (ge) begin
            num    = dh;
            direct = DRW'(dh) - DRW'(vx);
            if (!vneg) begin
               ctl_in.lane[a].kind = CAND_DIRECT;
            end
         end else if (vneg) begin
            dn = -vx;
         end else if (!vzero) begin
            num = dh;
         end else begin
            ctl_in.lane[a].kind = CAND_NONE;
         end
         ctl_in.lane[a].neg = num[P] ^ dn[V];
         num_abs   = num[P] ? -num : num;
         den_abs   = dn[V] ? -dn : dn;
         den_in[a] = den_abs[V-1:0];
         if (ctl_in.lane[a].kind == CAND_DIRECT) begin
            dq_in[a] = QW'(direct);
         end else begin
            dq_in[a] = QW'({num_abs[P-1:0], {FRAC_BITS{1'b0}}});
         end
      end
   end

   assign ctl_in.valid = take;

   // entry register of the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_in.valid;
      end
      ctl_ff.lane <= ctl_in.lane;
      den_ff      <= den_in;
      dq_ff       <= dq_in;
   end

   assign ctl_out = ctl_ff;
   assign den_out = den_ff;
   assign dq_out  = dq_ff;
   assign rem_out = '0;

endmodule

[rtl/bbtti_cell.sv]
module bbtti_cell
   import bbtti_pkg::*;
#(
   parameter int VEL_WIDTH = 16,
   parameter int NW        = 32,
   parameter int QW        = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pipe_ctl_type                       ctl_i,
   input  logic [NUM_AXES-1:0][VEL_WIDTH-1:0] rem_i,
   input  logic [NUM_AXES-1:0][VEL_WIDTH-1:0] den_i,
   input  logic [NUM_AXES-1:0][QW-1:0]        dq_i,
   output pipe_ctl_type                       ctl_o,
   output logic [NUM_AXES-1:0][VEL_WIDTH-1:0] rem_o,
   output logic [NUM_AXES-1:0][VEL_WIDTH-1:0] den_o,
   output logic [NUM_AXES-1:0][QW-1:0]        dq_o
);

   localparam int V = VEL_WIDTH;

   pipe_ctl_type                  ctl_ff;
   logic [NUM_AXES-1:0][V-1:0]    rem_ff, rem_in, den_ff;
   logic [NUM_AXES-1:0][QW-1:0]   dq_ff, dq_in;

   // one restoring step: dividend bit in at the top, quotient bit in at the bottom
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
      logic [V:0] t;
      logic       fits;

      always_comb begin
         t      = {rem_i[a], dq_i[a][NW-1]};
         fits   = t >= {1'b0, den_i[a]};
         rem_in[a] = fits ? V'(t - {1'b0, den_i[a]}) : t[V-1:0];
         dq_in[a]  = dq_i[a];
         if (ctl_i.lane[a].kind == CAND_QUOT) begin
            dq_in[a][NW-1:0] = {dq_i[a][NW-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.valid <= 1'b0;
      end else begin
         ctl_ff.valid <= ctl_i.valid;
      end
      ctl_ff.lane <= ctl_i.lane;
      rem_ff      <= rem_in;
      den_ff      <= den_i;
      dq_ff       <= dq_in;
   end

   assign ctl_o = ctl_ff;
   assign rem_o = rem_ff;
   assign den_o = den_ff;
   assign dq_o  = dq_ff;

endmodule

[rtl/bbtti_sel.sv]
module bbtti_sel
   import bbtti_pkg::*;
#(
   parameter int FRAC_BITS = 8,
   parameter int NW        = 32,
   parameter int QW        = 32,
   parameter int DRW       = 26
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pipe_ctl_type                  ctl_i,
   input  logic [NUM_AXES-1:0][QW-1:0]   dq_i,
   output logic                          valid_o,
   output logic [RES_WIDTH-1:0]          time_o,
   output logic                          clipped_o
);

   localparam int CW = (NW + 1 > DRW) ? NW + 1 : DRW;
   localparam logic signed [CW-1:0] CAP    = CW'(CAP_SECONDS) <<< FRAC_BITS;
   localparam logic signed [CW-1:0] LIM_LO = -(CW'(1) <<< (RES_WIDTH - 1));
   localparam logic signed [CW-1:0] LIM_HI = (CW'(1) <<< (RES_WIDTH - 1)) - CW'(1);

   logic                                 va_ff, vb_ff;
   logic signed [NUM_AXES-1:0][CW-1:0]   cand_ff, cand_in;
   logic [RES_WIDTH-1:0]                 time_ff, time_in;
   logic                                 clip_ff, clip_in;
   logic signed [CW-1:0]                 best;

   // signed candidate of each axis; an axis without one stands at the cap
   for (genvar a = 0; a < NUM_AXES; a++) begin : g_cand
      logic signed [CW-1:0] q;
      always_comb begin
         q = $signed(CW'(dq_i[a][NW-1:0]));
         unique case (ctl_i.lane[a].kind)
            CAND_QUOT:   cand_in[a] = ctl_i.lane[a].neg ? -q : q;
            CAND_DIRECT: cand_in[a] = CW'($signed(dq_i[a][DRW-1:0]));
            default:     cand_in[a] = CAP;
         endcase
      end
   end

   // minimum with the cap, then saturation to the result width
   always_comb begin
      best = CAP;
      for (int a = 0; a < NUM_AXES; a++) begin
         if ($signed(cand_ff[a]) < best) begin
            best = cand_ff[a];
         end
      end
      clip_in = 1'b0;
      priority if (best < LIM_LO) begin
         time_in = RES_WIDTH'(LIM_LO);
         clip_in = 1'b1;
      end else if (best > LIM_HI) begin
         time_in = RES_WIDTH'(LIM_HI);
      end else begin
         time_in = best[RES_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= ctl_i.valid;
         vb_ff <= va_ff;
      end
      cand_ff <= cand_in;
      time_ff <= time_in;
      clip_ff <= clip_in;
   end

   assign valid_o   = vb_ff;
   assign time_o    = time_ff;
   assign clipped_o = clip_ff;

endmodule

[rtl/box_boundary_time_to_impact.sv]
// channel | ports                                       | transfer when
// --------+---------------------------------------------+-------------------------
// request | req_*_pos, req_*_vel                        | start && !busy
// result  | rsp_impact_time, rsp_clipped                | rsp_valid (one cycle)
// config  | csr_index, csr_data                         | csr_valid && csr_ready
//
// A sample is taken every cycle; busy stays low, csr_ready stays high.
// The pipeline is one entry register, one divider cell per quotient bit,
// a candidate and a minimum stage.
// Synchronous reset clears the pipeline valid bits and loads the box bounds.
// Results cannot be held off and leave on the strobe cycle.
module box_boundary_time_to_impact
   import bbtti_pkg::*;
#(
   parameter int FRAC_BITS = 8,
   parameter int POS_WIDTH = 24,
   parameter int VEL_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [POS_WIDTH-1:0]     req_east_pos,
   input  logic [POS_WIDTH-1:0]     req_north_pos,
   input  logic [POS_WIDTH-1:0]     req_up_pos,
   input  logic [VEL_WIDTH-1:0]     req_east_vel,
   input  logic [VEL_WIDTH-1:0]     req_north_vel,
   input  logic [VEL_WIDTH-1:0]     req_up_vel,
   output logic                     rsp_valid,
   output logic [RES_WIDTH-1:0]     rsp_impact_time,
   output logic                     rsp_clipped,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [POS_WIDTH-1:0]     csr_data
);

   localparam int NW  = POS_WIDTH + FRAC_BITS;
   localparam int DRW = (POS_WIDTH > VEL_WIDTH ? POS_WIDTH : VEL_WIDTH) + 2;
   localparam int QW  = NW > DRW ? NW : DRW;
   localparam int LAT = NW + 3;
   localparam logic signed [RES_WIDTH-1:0] RES_MIN = {1'b1, {(RES_WIDTH-1){1'b0}}};

   logic [POS_WIDTH-1:0] n_lo_ff, n_hi_ff, e_lo_ff, e_hi_ff, u_lo_ff, u_hi_ff;
   logic                 take;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign take      = start && !busy;

   // box bound registers
   always_ff @(posedge clock) begin
      if (reset) begin
         n_lo_ff <= -POS_WIDTH'(2560);
         n_hi_ff <= POS_WIDTH'(2560);
         e_lo_ff <= -POS_WIDTH'(2560);
         e_hi_ff <= POS_WIDTH'(2560);
         u_lo_ff <= '0;
         u_hi_ff <= POS_WIDTH'(2560);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_NORTH_LOW:  n_lo_ff <= csr_data;
            REG_NORTH_HIGH: n_hi_ff <= csr_data;
            REG_EAST_LOW:   e_lo_ff <= csr_data;
            REG_EAST_HIGH:  e_hi_ff <= csr_data;
            REG_UP_LOW:     u_lo_ff <= csr_data;
            REG_UP_HIGH:    u_hi_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // chain links, lanes are north, east, up
   pipe_ctl_type                             ctl  [0:NW];
   logic [NUM_AXES-1:0][VEL_WIDTH-1:0]       rem  [0:NW];
   logic [NUM_AXES-1:0][VEL_WIDTH-1:0]       den  [0:NW];
   logic [NUM_AXES-1:0][QW-1:0]              dq   [0:NW];

   bbtti_prep #(
      .FRAC_BITS(FRAC_BITS), .POS_WIDTH(POS_WIDTH), .VEL_WIDTH(VEL_WIDTH), .QW(QW)
   ) u_prep (
      .clock   (clock),
      .reset   (reset),
      .take    (take),
      .pos     ({req_up_pos, req_east_pos, req_north_pos}),
      .vel     ({req_up_vel, req_east_vel, req_north_vel}),
      .lo      ({u_lo_ff, e_lo_ff, n_lo_ff}),
      .hi      ({u_hi_ff, e_hi_ff, n_hi_ff}),
      .ctl_out (ctl[0]),
      .rem_out (rem[0]),
      .den_out (den[0]),
      .dq_out  (dq[0])
   );

   for (genvar k = 0; k < NW; k++) begin : g_cell
      bbtti_cell #(
         .VEL_WIDTH(VEL_WIDTH), .NW(NW), .QW(QW)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctl_i (ctl[k]),
         .rem_i (rem[k]),
         .den_i (den[k]),
         .dq_i  (dq[k]),
         .ctl_o (ctl[k+1]),
         .rem_o (rem[k+1]),
         .den_o (den[k+1]),
         .dq_o  (dq[k+1])
      );
   end

   bbtti_sel #(
      .FRAC_BITS(FRAC_BITS), .NW(NW), .QW(QW), .DRW(DRW)
   ) u_sel (
      .clock     (clock),
      .reset     (reset),
      .ctl_i     (ctl[NW]),
      .dq_i      (dq[NW]),
      .valid_o   (rsp_valid),
      .time_o    (rsp_impact_time),
      .clipped_o (rsp_clipped)
   );

   // every taken sample leaves after the fixed latency
   a_latency: assert property (@(posedge clock) disable iff (reset)
      take |-> ##LAT rsp_valid)
      else $error("sample lost in pipeline");

   // a clipped result sits at the most negative code
   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |-> $signed(rsp_impact_time) == RES_MIN)
      else $error("clipped result not at minimum");

   // no result strobe without a sample taken earlier
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(ctl[NW].valid, 2))
      else $error("result without sample");

endmodule
